// ===== design/sliding_window_anagram_match_macros.svh =====
// Assertion macros for the sliding window anagram match checker.
`ifndef SLIDING_WINDOW_ANAGRAM_MATCH_MACROS_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCH_MACROS_SVH

// Same-cycle implication, off during reset.
`define SWAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define SWAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// State in the cycle after a reset cycle.
`define SWAM_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/swam_pkg.sv =====
// Types and constants shared by the sliding window anagram match modules.
package swam_pkg;

    localparam int SYM_W       = 5;
    localparam int REQ_W       = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [SYM_W-1:0] sym;
        logic             known;
    } t_req;

    typedef struct packed {
        logic             restart;
        logic             pat_add;
        logic             text;
        logic             empty;
        logic             dec;
        logic             full;
        logic             ovf;
        logic             known;
        logic [SYM_W-1:0] sym;
    } t_op;

    typedef struct packed {
        logic pattern_overflow;
        logic found;
        logic window_match;
    } t_result;

endpackage

// ===== design/swam_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
module swam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/swam_front.sv =====
// Front end: accepts input words, classifies them and queues them in a two-entry FIFO.
module swam_front import swam_pkg::*; #(
    parameter int ALPHABET = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  logic [REQ_W-1:0] i_kind,
    input  logic [SYM_W-1:0] i_sym,
    output logic             o_q_valid,
    output t_req             o_q_head,
    input  logic             i_q_pop
);

    t_req       r_q_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_keep;
    logic       w_push;
    t_req       w_req;

    assign o_s_ready = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_head  = r_q_mem[r_rd_ptr];

    // unused request codes are taken and dropped here
    assign w_keep = i_kind inside {REQ_PATTERN, REQ_TEXT, REQ_RESTART};
    assign w_push = i_s_valid && o_s_ready && w_keep;

    always_comb begin
        w_req.kind  = i_kind;
        w_req.sym   = i_sym;
        w_req.known = (int'(i_sym) < ALPHABET);
    end

    always_comb begin
        n_count = r_count;
        case ({w_push, i_q_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wr_ptr] <= w_req;
        end
    end

endmodule

// ===== design/swam_seq.sv =====
// Back end, first stage: pattern length, window fill, ring pointer and window ring.
module swam_seq import swam_pkg::*; #(
    parameter int MAX_PATTERN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_req             i_q_head,
    output logic             o_q_pop,
    output logic             o_op_valid,
    output t_op              o_op,
    output logic [SYM_W-1:0] o_old_sym,
    input  logic             i_op_take
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int EXT_W = CNT_W + 1;
    localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CNT_W-1:0] r_plen;
    logic [CNT_W-1:0] r_fill;
    logic [PTR_W-1:0] r_ptr;
    logic             r_ovf;
    logic             r_op_valid;
    t_op              r_op;

    logic [CNT_W-1:0] n_plen;
    logic [CNT_W-1:0] n_fill;
    logic [PTR_W-1:0] n_ptr;
    logic             n_ovf;
    t_op              n_op;

    logic             w_pop;
    logic             w_is_pat;
    logic             w_is_txt;
    logic             w_is_rst;
    logic             w_pat_open;
    logic             w_pat_full;
    logic             w_txt_win;
    logic             w_win_full;
    logic [CNT_W-1:0] w_fill_after;
    logic [EXT_W-1:0] w_ptr_ext;
    logic [EXT_W-1:0] w_old_ext;
    logic [PTR_W-1:0] w_old_slot;
    logic [PTR_W-1:0] w_ptr_inc;

    assign w_pop   = i_q_valid && (!r_op_valid || i_op_take);
    assign o_q_pop = w_pop;

    assign w_is_pat = (i_q_head.kind == REQ_PATTERN);
    assign w_is_txt = (i_q_head.kind == REQ_TEXT);
    assign w_is_rst = (i_q_head.kind == REQ_RESTART);

    assign w_pat_open   = w_is_pat && (r_fill == '0) && i_q_head.known;
    assign w_pat_full   = (r_plen == CNT_W'(MAX_PATTERN));
    assign w_txt_win    = w_is_txt && (r_plen != '0);
    assign w_win_full   = (r_fill == r_plen);
    assign w_fill_after = w_win_full ? r_fill : r_fill + 1'b1;

    // slot of the symbol leaving the window
    assign w_ptr_ext  = EXT_W'(r_ptr);
    assign w_old_ext  = (w_ptr_ext >= EXT_W'(r_plen))
                      ? w_ptr_ext - EXT_W'(r_plen)
                      : w_ptr_ext + EXT_W'(MAX_PATTERN) - EXT_W'(r_plen);
    assign w_old_slot = w_old_ext[PTR_W-1:0];
    assign w_ptr_inc  = (r_ptr == PTR_W'(MAX_PATTERN - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_plen = r_plen;
        n_fill = r_fill;
        n_ptr  = r_ptr;
        n_ovf  = r_ovf;
        if (w_is_rst) begin
            n_plen = '0;
            n_fill = '0;
            n_ptr  = '0;
            n_ovf  = 1'b0;
        end else if (w_pat_open) begin
            if (w_pat_full) begin
                n_ovf = 1'b1;
            end else begin
                n_plen = r_plen + 1'b1;
            end
        end else if (w_txt_win) begin
            n_fill = w_fill_after;
            n_ptr  = w_ptr_inc;
        end
    end

    always_comb begin
        n_op.restart = w_is_rst;
        n_op.pat_add = w_pat_open && !w_pat_full;
        n_op.text    = w_is_txt;
        n_op.empty   = w_is_txt && (r_plen == '0);
        n_op.dec     = w_txt_win && w_win_full;
        n_op.full    = (w_fill_after == r_plen);
        n_op.ovf     = n_ovf;
        n_op.known   = i_q_head.known;
        n_op.sym     = i_q_head.sym;
    end

    swam_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_pop && w_txt_win),
        .i_waddr (r_ptr),
        .i_wdata (i_q_head.sym),
        .i_re    (w_pop),
        .i_raddr (w_old_slot),
        .o_rdata (o_old_sym)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen     <= '0;
            r_fill     <= '0;
            r_ptr      <= '0;
            r_ovf      <= 1'b0;
            r_op_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_plen <= n_plen;
                r_fill <= n_fill;
                r_ptr  <= n_ptr;
                r_ovf  <= n_ovf;
            end
            if (w_pop) begin
                r_op_valid <= 1'b1;
            end else if (i_op_take) begin
                r_op_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_op_valid;
    assign o_op       = r_op;

endmodule

// ===== design/swam_hist.sv =====
// Back end, second stage: per-letter count cells, match decision and output register.
module swam_hist import swam_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int ALPHABET    = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_op_valid,
    input  t_op              i_op,
    input  logic [SYM_W-1:0] i_old_sym,
    output logic             o_op_take,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output t_result          o_m_result
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic [CNT_W-1:0] r_pcnt [ALPHABET];
    logic [CNT_W-1:0] r_wcnt [ALPHABET];
    logic             r_found;
    logic             r_m_valid;
    t_result          r_result;

    logic [CNT_W-1:0] n_pcnt [ALPHABET];
    logic [CNT_W-1:0] n_wcnt [ALPHABET];
    logic [ALPHABET-1:0] n_diff;

    logic             w_take;
    logic             w_old_known;
    logic             w_match;
    logic             w_win_op;

    assign w_take      = i_op_valid && (!i_op.text || !r_m_valid || i_m_ready);
    assign o_op_take   = w_take;
    assign w_old_known = (int'(i_old_sym) < ALPHABET);
    assign w_win_op    = i_op.text && !i_op.empty;

    always_comb begin
        logic [CNT_W-1:0] w_mid;
        for (int i = 0; i < ALPHABET; i++) begin
            w_mid = r_wcnt[i];
            if (i_op.dec && w_old_known && (int'(i_old_sym) == i) && (r_wcnt[i] != '0)) begin
                w_mid = r_wcnt[i] - 1'b1;
            end
            if (i_op.restart) begin
                n_pcnt[i] = '0;
                n_wcnt[i] = '0;
            end else begin
                n_pcnt[i] = (i_op.pat_add && (int'(i_op.sym) == i))
                          ? r_pcnt[i] + 1'b1 : r_pcnt[i];
                n_wcnt[i] = (w_win_op && i_op.known && (int'(i_op.sym) == i))
                          ? w_mid + 1'b1 : w_mid;
            end
            n_diff[i] = (n_pcnt[i] != n_wcnt[i]);
        end
    end

    assign w_match = i_op.empty || (i_op.full && (n_diff == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHABET; i++) begin
                r_pcnt[i] <= '0;
                r_wcnt[i] <= '0;
            end
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_take) begin
                for (int i = 0; i < ALPHABET; i++) begin
                    r_pcnt[i] <= n_pcnt[i];
                    r_wcnt[i] <= n_wcnt[i];
                end
                if (i_op.restart) begin
                    r_found <= 1'b0;
                end else if (i_op.text) begin
                    r_found <= r_found | w_match;
                end
            end
            if (w_take && i_op.text) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_op.text) begin
            r_result.window_match     <= w_match;
            r_result.found            <= r_found | w_match;
            r_result.pattern_overflow <= i_op.ovf;
        end
    end

    assign o_m_valid  = r_m_valid;
    assign o_m_result = r_result;

endmodule

// ===== design/sliding_window_anagram_match.sv =====
// Top level of the sliding window anagram match block.
//
// Input stream: tuser carries the request (pattern symbol, text symbol,
// restart); tdata carries the letter code. Pattern symbols build the
// pattern histogram; each text symbol yields exactly one output word with
// the window match bit, the sticky found bit and the pattern overflow bit.
// Restart words and pattern words yield no output.
// The output word passes the queue entry, the ring/control stage and the
// output register in turn.
// Throughput: one word per cycle, sustained, while the output is taken;
// each text word updates at most two count cells and one ring entry.
// The ring RAM is read and written at most once per cycle by the control stage.
// Reset clears all counts, pointers and flags; a restart word clears the
// counts, the ring pointer and the found and overflow flags in stream order.
// When the receiver stalls, the output register holds its word, the two
// pipeline stages and the two-entry input queue fill, and then tready drops.
module sliding_window_anagram_match import swam_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int ALPHABET    = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [4:0] symbol
    input  logic [REQ_W-1:0]       i_s_axis_tuser,  // [1:0] req_type
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // [0] window_match, [1] found,
                                                    // [2] pattern_overflow
);

    logic             w_q_valid;
    t_req             w_q_head;
    logic             w_q_pop;
    logic             w_op_valid;
    t_op              w_op;
    logic [SYM_W-1:0] w_old_sym;
    logic             w_op_take;
    t_result          w_result;

    swam_front #(
        .ALPHABET (ALPHABET)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_kind    (i_s_axis_tuser),
        .i_sym     (i_s_axis_tdata[SYM_W-1:0]),
        .o_q_valid (w_q_valid),
        .o_q_head  (w_q_head),
        .i_q_pop   (w_q_pop)
    );

    swam_seq #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_head   (w_q_head),
        .o_q_pop    (w_q_pop),
        .o_op_valid (w_op_valid),
        .o_op       (w_op),
        .o_old_sym  (w_old_sym),
        .i_op_take  (w_op_take)
    );

    swam_hist #(
        .MAX_PATTERN (MAX_PATTERN),
        .ALPHABET    (ALPHABET)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .i_old_sym  (w_old_sym),
        .o_op_take  (w_op_take),
        .o_m_valid  (o_m_axis_tvalid),
        .i_m_ready  (i_m_axis_tready),
        .o_m_result (w_result)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, w_result};

endmodule

// ===== design/swam_checker.sv =====
// Port-level checker for the sliding window anagram match block, with its bind.
`include "sliding_window_anagram_match_macros.svh"

module swam_checker import swam_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    `SWAM_ASSERT_RST(a_reset_state, i_clk, i_rst_n, !o_m_axis_tvalid && o_s_axis_tready, "output valid or input stalled after reset")
    `SWAM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled output word changed")
    `SWAM_ASSERT_IMP(a_match_found, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[0], o_m_axis_tdata[1], "window match without found")
    `SWAM_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[OUT_TDATA_W-1:3] == '0, "output padding not zero")

endmodule

bind sliding_window_anagram_match swam_checker u_swam_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/anagram_window_checker.sv =====
// Checker: predicts anagram-window results from accepted words and compares them.
module anagram_window_checker import swam_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int ALPHABET    = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [4:0] symbol
    input  logic [REQ_W-1:0]       i_s_tuser,   // [1:0] req_type
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // [0] window_match, [1] found,
                                                // [2] pattern_overflow
    output int                     o_failures,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [6:0]       pat_hist [ALPHABET];
    logic [6:0]       win_hist [ALPHABET];
    logic [SYM_W-1:0] win_syms [MAX_PATTERN];
    int               head;
    int               pat_len;
    int               win_fill;
    int               n_differ;
    logic             found_q;
    logic             ovf_q;
    t_result          expected_results [$];

    function automatic void clear_state();
        for (int i = 0; i < ALPHABET; i++) begin
            pat_hist[i] = '0;
            win_hist[i] = '0;
        end
        for (int i = 0; i < MAX_PATTERN; i++) win_syms[i] = '0;
        head     = 0;
        pat_len  = 0;
        win_fill = 0;
        n_differ = 0;
        found_q  = 1'b0;
        ovf_q    = 1'b0;
    endfunction

    // Move one histogram cell and keep the count of differing letters in step.
    function automatic void move_count(bit in_window, int letter, bit up);
        bit was_diff;
        bit now_diff;
        was_diff = pat_hist[letter] != win_hist[letter];
        if (in_window) begin
            if (up) win_hist[letter] = win_hist[letter] + 7'd1;
            else if (win_hist[letter] != 0) win_hist[letter] = win_hist[letter] - 7'd1;
        end else begin
            pat_hist[letter] = pat_hist[letter] + 7'd1;
        end
        now_diff = pat_hist[letter] != win_hist[letter];
        if (now_diff && !was_diff) n_differ++;
        else if (was_diff && !now_diff && n_differ > 0) n_differ--;
    endfunction

    function automatic void predict_window(logic [REQ_W-1:0] kind, logic [SYM_W-1:0] sym);
        bit      known;
        bit      hit;
        int      old_slot;
        t_result res;
        known = int'(sym) < ALPHABET;
        case (kind)
            REQ_RESTART: begin
                clear_state();
            end
            REQ_PATTERN: begin
                if (win_fill == 0 && known) begin
                    if (pat_len >= MAX_PATTERN) begin
                        ovf_q = 1'b1;
                    end else begin
                        move_count(1'b0, int'(sym), 1'b1);
                        pat_len++;
                    end
                end
            end
            REQ_TEXT: begin
                if (pat_len == 0) begin
                    hit = 1'b1;
                end else begin
                    if (win_fill >= pat_len) begin
                        old_slot = (head + MAX_PATTERN - pat_len) % MAX_PATTERN;
                        if (int'(win_syms[old_slot]) < ALPHABET)
                            move_count(1'b1, int'(win_syms[old_slot]), 1'b0);
                    end else begin
                        win_fill++;
                    end
                    if (known) move_count(1'b1, int'(sym), 1'b1);
                    win_syms[head] = sym;
                    head = (head + 1) % MAX_PATTERN;
                    hit = (win_fill == pat_len) && (n_differ == 0);
                end
                if (hit) found_q = 1'b1;
                res.window_match     = hit;
                res.found            = found_q;
                res.pattern_overflow = ovf_q;
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(string name, logic exp_v, logic act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0b, actual %0b", name, exp_v, act_v);
            o_failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            clear_state();
            expected_results.delete();
            o_failures = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("output word 0x%02h with no prediction waiting", i_m_tdata);
                    o_failures++;
                end else begin
                    exp_r = expected_results.pop_front();
                    compare_field("window_match", exp_r.window_match, i_m_tdata[0]);
                    compare_field("found", exp_r.found, i_m_tdata[1]);
                    compare_field("pattern_overflow", exp_r.pattern_overflow, i_m_tdata[2]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_window(i_s_tuser, i_s_tdata[SYM_W-1:0]);
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, pattern/text stimulus and the final verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import swam_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     failures;
    int                     pending;

    bit                     no_idle;
    bit                     hold_off_req;
    int                     items;
    logic [SYM_W-1:0]       letters [$];
    logic [SYM_W-1:0]       shuffled [$];

    sliding_window_anagram_match DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    anagram_window_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_failures (failures),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(15, 40);
        return $urandom_range(1, 3);
    endfunction

    // One word on the input stream; returns after its accepting edge.
    task automatic send_word(logic [REQ_W-1:0] kind, logic [SYM_W-1:0] sym);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-SYM_W){1'b0}}, sym};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        items++;
    endtask

    task automatic reshuffle();
        int               j;
        logic [SYM_W-1:0] tmp;
        shuffled = letters;
        for (int i = shuffled.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = shuffled[i];
            shuffled[i] = shuffled[j];
            shuffled[j] = tmp;
        end
    endtask

    // Restart, a pattern, then text made mostly of pattern letters, partly as permutations of the pattern.
    task automatic run_sequence(bit force_full);
        int               plen;
        int               tlen;
        int               pick;
        int               span;
        logic [SYM_W-1:0] sym;
        no_idle = ($urandom_range(0, 4) == 0);
        letters.delete();
        shuffled.delete();
        send_word(REQ_RESTART, SYM_W'($urandom_range(0, 31)));
        pick = $urandom_range(0, 19);
        span = $urandom_range(2, 26);
        if (force_full) begin
            plen = $urandom_range(66, 70);
            span = $urandom_range(2, 4);
        end else if (pick == 0) begin
            plen = $urandom_range(62, 68);
            span = $urandom_range(2, 4);
        end else if (pick == 1) begin
            plen = 0;
        end else begin
            plen = $urandom_range(1, 6);
        end
        for (int i = 0; i < plen; i++) begin
            if (!force_full && $urandom_range(0, 19) == 0) sym = SYM_W'($urandom_range(26, 31));
            else sym = SYM_W'($urandom_range(0, span - 1));
            send_word(REQ_PATTERN, sym);
            if (sym < 26 && letters.size() < 64) letters.push_back(sym);
        end
        tlen = (plen > 20) ? $urandom_range(70, 140) : $urandom_range(8, 40);
        for (int i = 0; i < tlen; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9 && letters.size() > 0) begin
                if (shuffled.size() == 0) reshuffle();
                send_word(REQ_TEXT, shuffled.pop_front());
            end else if (pick < 15) begin
                if (letters.size() > 0) sym = letters[$urandom_range(0, letters.size() - 1)];
                else sym = SYM_W'($urandom_range(0, 25));
                send_word(REQ_TEXT, sym);
            end else if (pick < 17) begin
                send_word(REQ_TEXT, SYM_W'($urandom_range(0, 31)));
            end else if (pick == 17) begin
                send_word(REQ_UNUSED, SYM_W'($urandom_range(0, 31)));
            end else if (pick == 18) begin
                send_word(REQ_PATTERN, SYM_W'($urandom_range(0, 25)));
            end else begin
                send_word(REQ_TEXT, SYM_W'($urandom_range(0, span - 1)));
            end
        end
    endtask

    // Receiver side
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (299) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len() - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        bit held;
        held         = 1'b0;
        items        = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_PATTERN;
        i_rst_n      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty pattern matches every text word
        send_word(REQ_TEXT, 5'd0);
        send_word(REQ_TEXT, 5'd31);
        send_word(REQ_RESTART, 5'd0);
        // extreme letters, foreign letter dropped from the pattern
        send_word(REQ_PATTERN, 5'd0);
        send_word(REQ_PATTERN, 5'd25);
        send_word(REQ_PATTERN, 5'd31);
        send_word(REQ_TEXT, 5'd25);
        send_word(REQ_TEXT, 5'd0);
        send_word(REQ_TEXT, 5'd31);
        send_word(REQ_TEXT, 5'd0);
        send_word(REQ_TEXT, 5'd25);
        // pattern word after text is ignored
        send_word(REQ_PATTERN, 5'd25);
        send_word(REQ_TEXT, 5'd0);
        send_word(REQ_TEXT, 5'd26);
        send_word(REQ_UNUSED, 5'd7);
        send_word(REQ_UNUSED, 5'd24);
        send_word(REQ_RESTART, 5'd31);
        send_word(REQ_TEXT, 5'd12);

        // full pattern with overflow first, then mixed sequences
        run_sequence(1'b1);
        while (items < 500) begin
            if (!held && items > 200) begin
                hold_off_req = 1'b1;
                held = 1'b1;
            end
            run_sequence(1'b0);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
